FILE: rtl/u8u16_pkg.sv
package u8u16_pkg;

    // Capacity register reset value (code units, terminator included)
    localparam logic [15:0] MAX_UNITS_RESET = 16'd256;

    // Unit emitted in place of an unsupported lead byte ('?')
    localparam logic [15:0] SUBST_UNIT = 16'h003F;

    // Lead byte classification masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;

    // Bytes still expected after a lead byte
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_SKIP = 2'd3;

    // Result queue geometry
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // One result item
    typedef struct packed {
        logic [15:0] string_length;
        logic        is_terminator;
        logic [15:0] unit_index;
        logic [15:0] code_unit;
    } res_t;

    // Results produced by one input byte (at most two)
    typedef struct packed {
        logic v0;
        res_t r0;
        logic v1;
        res_t r1;
    } dec_out_t;

endpackage

FILE: rtl/u8u16_decode.sv
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  in_byte,
    input  logic        string_start,
    input  logic [15:0] max_units,
    output dec_out_t    dec_out
);

    logic [1:0]  pend_reg, pend_next;
    logic        skip_reg, skip_next;
    logic [15:0] pv_reg, pv_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        done_reg, done_next;

    logic [1:0]  pend_cur;
    logic        skip_cur;
    logic [15:0] pv_cur;
    logic [15:0] cnt_cur;
    logic        done_cur;
    logic [15:0] limit;
    logic [15:0] cnt_inc;
    logic [15:0] pv_merged;
    logic        emit;
    logic [15:0] unit;

    // Decode one byte against the current string state
    always_comb begin
        pend_cur = string_start ? PEND_NONE : pend_reg;
        skip_cur = string_start ? 1'b0 : skip_reg;
        pv_cur   = string_start ? 16'd0 : pv_reg;
        cnt_cur  = string_start ? 16'd0 : cnt_reg;
        done_cur = string_start ? 1'b0 : done_reg;
        limit    = (max_units == 16'd0) ? 16'd0 : max_units - 16'd1;
        cnt_inc  = cnt_cur + 16'd1;
        pv_merged = pv_cur | ((pend_cur == PEND_TWO) ? {4'd0, in_byte[5:0], 6'd0}
                                                     : {10'd0, in_byte[5:0]});

        pend_next = pend_cur;
        skip_next = skip_cur;
        pv_next   = pv_cur;
        cnt_next  = cnt_cur;
        done_next = done_cur;
        emit      = 1'b0;
        unit      = 16'd0;
        dec_out   = '0;

        if (done_cur) begin
            // Drop bytes after the terminator
        end else if (cnt_cur >= limit) begin
            dec_out.v0 = 1'b1;
            dec_out.r0.unit_index    = cnt_cur;
            dec_out.r0.is_terminator = 1'b1;
            dec_out.r0.string_length = cnt_cur;
            done_next = 1'b1;
            pend_next = PEND_NONE;
            skip_next = 1'b0;
        end else if (skip_cur) begin
            pend_next = pend_cur - 2'd1;
            if (pend_cur == PEND_ONE) begin
                skip_next = 1'b0;
            end
        end else if (pend_cur != PEND_NONE) begin
            pv_next   = pv_merged;
            pend_next = pend_cur - 2'd1;
            if (pend_cur == PEND_ONE) begin
                emit = 1'b1;
                unit = pv_merged;
            end
        end else if (!in_byte[7]) begin
            if (in_byte == 8'd0) begin
                dec_out.v0 = 1'b1;
                dec_out.r0.unit_index    = cnt_cur;
                dec_out.r0.is_terminator = 1'b1;
                dec_out.r0.string_length = cnt_cur;
                done_next = 1'b1;
            end else begin
                emit = 1'b1;
                unit = {9'd0, in_byte[6:0]};
            end
        end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
            pv_next   = {5'd0, in_byte[4:0], 6'd0};
            pend_next = PEND_ONE;
        end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
            pv_next   = {in_byte[3:0], 12'd0};
            pend_next = PEND_TWO;
        end else begin
            emit      = 1'b1;
            unit      = SUBST_UNIT;
            skip_next = 1'b1;
            pend_next = PEND_SKIP;
        end

        // Emit a unit, and the terminator too when capacity is reached
        if (emit) begin
            dec_out.v0 = 1'b1;
            dec_out.r0.code_unit  = unit;
            dec_out.r0.unit_index = cnt_cur;
            cnt_next = cnt_inc;
            if (cnt_inc >= limit) begin
                dec_out.v1 = 1'b1;
                dec_out.r1.unit_index    = cnt_inc;
                dec_out.r1.is_terminator = 1'b1;
                dec_out.r1.string_length = cnt_inc;
                done_next = 1'b1;
                pend_next = PEND_NONE;
                skip_next = 1'b0;
            end
        end
    end

    // Hold string state; advance on each decoded byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE;
            skip_reg <= 1'b0;
            pv_reg   <= 16'd0;
            cnt_reg  <= 16'd0;
            done_reg <= 1'b0;
        end else if (fire) begin
            pend_reg <= pend_next;
            skip_reg <= skip_next;
            pv_reg   <= pv_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

`ifndef SYNTHESIS
    a_second_is_term: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_out.v1 |-> dec_out.v0 && !dec_out.r0.is_terminator && dec_out.r1.is_terminator)
        else $error("second result without unit before terminator");

    a_done_after_term: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && ((dec_out.v0 && dec_out.r0.is_terminator) || dec_out.v1) |=> done_reg)
        else $error("string not closed after terminator");

    a_len_only_term: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_out.v0 && !dec_out.r0.is_terminator |-> dec_out.r0.string_length == 16'd0)
        else $error("length on a non-terminator result");

    a_skip_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> pend_reg != PEND_NONE)
        else $error("skipping with nothing left to discard");
`endif

endmodule

FILE: rtl/u8u16_outq.sv
module u8u16_outq
    import u8u16_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  dec_out_t dec_out,
    output logic     space_ok,
    output logic     out_valid,
    input  logic     out_ready,
    output res_t     out_res
);

    res_t                 mem_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0]   count_reg, count_next;
    logic                 wr0, wr1, pop;
    logic [OUTQ_AW-1:0]   wr_ptr_plus1;

    // Room for a full pair of results
    assign space_ok  = count_reg <= OUTQ_CW'(OUTQ_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr0          = push && dec_out.v0;
        wr1          = push && dec_out.v1;
        pop          = out_valid && out_ready;
        wr_ptr_plus1 = wr_ptr_reg + OUTQ_AW'(1);
        wr_ptr_next  = wr_ptr_reg + OUTQ_AW'(wr0) + OUTQ_AW'(wr1);
        rd_ptr_next  = rd_ptr_reg + OUTQ_AW'(pop);
        count_next   = count_reg + OUTQ_CW'(wr0) + OUTQ_CW'(wr1) - OUTQ_CW'(pop);
    end

    // Store results in arrival order
    always_ff @(posedge aclk) begin
        if (wr0) begin
            mem_reg[wr_ptr_reg] <= dec_out.r0;
        end
        if (wr1) begin
            mem_reg[wr_ptr_plus1] <= dec_out.r1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> space_ok)
        else $error("push without room for two results");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != OUTQ_CW'(OUTQ_DEPTH) |->
            OUTQ_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[OUTQ_AW-1:0])
        else $error("pointers disagree with occupancy");
`endif

endmodule

FILE: rtl/utf8_to_utf16_bmp_decoder_top.sv
// Channel   Dir  Transaction payload
// s_axis    in   tdata: in_byte[7:0]; tuser: string_start
// m_axis    out  tdata: code_unit[15:0], unit_index[31:16], string_length[47:32];
//                tlast: is_terminator
// cfg       in   cfg_wr_data: max_units (written when cfg_wr_en is high)
//
// One byte per cycle is taken while the queue has room for two results; a byte is
// held in the input register and decoded from there into a four-entry result queue.
// A byte yields zero, one or two results; the result port drains one per ready cycle,
// so the queue's free space (room for two) sets when the input register advances.
// Reset (aresetn low, synchronous) clears string state, queue and max_units to 256.
module utf8_to_utf16_bmp_decoder_top
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] string_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] code_unit, [31:16] unit_index,
                                        // [47:32] string_length
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic [15:0] max_units_reg;
    logic        space_ok;
    logic        fire;
    logic        s_accept;
    dec_out_t    dec_out;
    res_t        out_res;

    assign fire          = in_valid_reg && space_ok;
    assign s_axis_tready = !in_valid_reg || space_ok;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Hold the input transaction until it is decoded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_units_reg <= MAX_UNITS_RESET;
        end else if (cfg_wr_en) begin
            max_units_reg <= cfg_wr_data;
        end
    end

    u8u16_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .in_byte      (in_byte_reg),
        .string_start (in_start_reg),
        .max_units    (max_units_reg),
        .dec_out      (dec_out)
    );

    u8u16_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .dec_out   (dec_out),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result transaction
    assign m_axis_tdata = {out_res.string_length, out_res.unit_index, out_res.code_unit};
    assign m_axis_tlast = out_res.is_terminator;

endmodule

FILE: verif/utf8_to_utf16_bmp_decoder_top_tb.sv
`timescale 1ns / 100ps

module utf8_to_utf16_bmp_decoder_top_tb;
    import u8u16_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_LEN      = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    // Decoder model state
    logic [15:0] cap_units;
    logic [1:0]  seq_pending;
    bit          seq_skipping;
    logic [15:0] seq_payload;
    logic [15:0] units_written;
    bit          string_closed;

    // Code units still to arrive, oldest first
    res_t        awaited_units[$];

    int          errors;
    int          bytes_sent;
    int          units_checked;
    int          terminators_seen;
    int          cap_writes;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;
    int          hold_request;
    bit          next_start;

    utf8_to_utf16_bmp_decoder_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Queue the terminator and close the string
    function automatic void close_string();
        res_t r;
        r.code_unit     = 16'h0000;
        r.unit_index    = units_written;
        r.is_terminator = 1'b1;
        r.string_length = units_written;
        awaited_units.push_back(r);
        string_closed = 1'b1;
        seq_pending   = PEND_NONE;
        seq_skipping  = 1'b0;
    endfunction

    // Work out the code units that one accepted byte produces
    function automatic void decode_byte(logic [7:0] b, bit start);
        logic [15:0] lim;
        logic [15:0] unit;
        res_t        r;
        lim = (cap_units == 16'd0) ? 16'd0 : cap_units - 16'd1;
        if (start) begin
            seq_pending   = PEND_NONE;
            seq_skipping  = 1'b0;
            seq_payload   = 16'h0000;
            units_written = 16'h0000;
            string_closed = 1'b0;
        end
        if (string_closed)
            return;
        if (units_written >= lim) begin
            close_string();
            return;
        end
        if (seq_skipping) begin
            seq_pending = seq_pending - 2'd1;
            if (seq_pending == PEND_NONE)
                seq_skipping = 1'b0;
            return;
        end
        if (seq_pending != PEND_NONE) begin
            seq_payload = seq_payload |
                ((seq_pending == PEND_TWO) ? {4'h0, b[5:0], 6'h00} : {10'h000, b[5:0]});
            seq_pending = seq_pending - 2'd1;
            if (seq_pending != PEND_NONE)
                return;
            unit = seq_payload;
        end else if (!b[7]) begin
            if (b == 8'h00) begin
                close_string();
                return;
            end
            unit = {8'h00, b};
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            seq_payload = {5'h00, b[4:0], 6'h00};
            seq_pending = PEND_ONE;
            return;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            seq_payload = {b[3:0], 12'h000};
            seq_pending = PEND_TWO;
            return;
        end else begin
            unit         = SUBST_UNIT;
            seq_skipping = 1'b1;
            seq_pending  = PEND_SKIP;
        end
        r.code_unit     = unit;
        r.unit_index    = units_written;
        r.is_terminator = 1'b0;
        r.string_length = 16'h0000;
        awaited_units.push_back(r);
        units_written = units_written + 16'd1;
        if (units_written >= lim)
            close_string();
    endfunction

    // Offer one byte, wait for its transaction, then predict
    task automatic send_byte(input logic [7:0] b, input bit start);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        decode_byte(b, start);
        bytes_sent++;
    endtask

    // Send a byte carrying the pending start flag
    task automatic put_byte(input logic [7:0] b);
        send_byte(b, next_start);
        next_start = 1'b0;
    endtask

    // Drop valid, wait for every awaited unit and let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_units.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [15:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_units = v;
        cap_writes++;
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(99) < 85)
            return {2'b10, 6'($urandom_range(63))};
        return 8'($urandom_range(255));
    endfunction

    // One string: mostly well-formed sequences, some bad leads and noise
    task automatic send_random_string();
        int n;
        int kind;
        n = $urandom_range(1, 14);
        next_start = 1'b1;
        repeat (n) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                put_byte(8'($urandom_range(1, 127)));
            end else if (kind < 60) begin
                put_byte({3'b110, 5'($urandom_range(31))});
                put_byte(cont_byte());
            end else if (kind < 80) begin
                put_byte({4'b1110, 4'($urandom_range(15))});
                put_byte(cont_byte());
                put_byte(cont_byte());
            end else if (kind < 88) begin
                if ($urandom_range(1))
                    put_byte(8'($urandom_range(8'hF0, 8'hFF)));
                else
                    put_byte(8'($urandom_range(8'h80, 8'hBF)));
                repeat (3) put_byte(8'($urandom_range(255)));
            end else begin
                send_byte(8'($urandom_range(255)), ($urandom_range(15) == 0));
            end
        end
        if ($urandom_range(99) < 75)
            put_byte(8'h00);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        int hold_left;
        int hold_seen;
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result transaction with the oldest awaited unit
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (awaited_units.size() == 0) begin
                $display("%0t: unexpected result unit=%h index=%0d last=%b len=%0d",
                         $time, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast,
                         m_axis_tdata[47:32]);
                errors++;
            end else begin
                want = awaited_units.pop_front();
                if (m_axis_tdata[15:0] !== want.code_unit) begin
                    $display("%0t: code_unit expected %h actual %h",
                             $time, want.code_unit, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[31:16] !== want.unit_index) begin
                    $display("%0t: unit_index expected %0d actual %0d",
                             $time, want.unit_index, m_axis_tdata[31:16]);
                    errors++;
                end
                if (m_axis_tlast !== want.is_terminator) begin
                    $display("%0t: is_terminator expected %b actual %b",
                             $time, want.is_terminator, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== want.string_length) begin
                    $display("%0t: string_length expected %0d actual %0d",
                             $time, want.string_length, m_axis_tdata[47:32]);
                    errors++;
                end
                if (want.is_terminator)
                    terminators_seen++;
            end
            units_checked++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d units outstanding",
                     cycle_count, awaited_units.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Extremes of each form, bad leads, starts mid-sequence, bytes around the end
    task automatic test_directed();
        send_byte(8'h41, 1'b0);     // before any start
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC0, 1'b0);     // zero byte as payload
        send_byte(8'h00, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF0, 1'b0);     // four-byte lead, zero among the skipped bytes
        send_byte(8'h9F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);     // stray continuation
        send_byte(8'hFF, 1'b1);     // start mid-skip, then bad lead again
        send_byte(8'hE2, 1'b1);     // start drops the skip
        send_byte(8'h00, 1'b1);     // start drops the open sequence, ends at once
        send_byte(8'h41, 1'b0);     // ignored after the end
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    // Capacity of one, zero, reaching the limit, the maximum, lowering mid-string
    task automatic test_capacity();
        set_capacity(16'd1);
        send_byte(8'h41, 1'b1);
        send_byte(8'h42, 1'b0);
        set_capacity(16'd0);
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b0);
        set_capacity(16'd3);
        send_byte(8'h61, 1'b1);
        send_byte(8'h62, 1'b0);
        send_byte(8'hE2, 1'b1);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'h78, 1'b0);
        set_capacity(16'd65535);
        send_byte(8'h30, 1'b1);
        for (int i = 1; i < 20; i++)
            send_byte(8'(8'h30 + i), 1'b0);
        send_byte(8'h00, 1'b0);
        set_capacity(16'd256);
        send_byte(8'h61, 1'b1);
        for (int i = 1; i < 10; i++)
            send_byte(8'(8'h61 + i), 1'b0);
        set_capacity(16'd4);
        send_byte(8'h7A, 1'b0);
        send_byte(8'h79, 1'b0);
    endtask

    // Random strings under one idling mode, capacity changed every few strings
    task automatic test_random_phase(input int n_bytes, input int idle, input int stall);
        int target;
        int strings;
        int pick;
        idle_pct  = idle;
        stall_pct = stall;
        target    = bytes_sent + n_bytes;
        strings   = 0;
        while (bytes_sent < target) begin
            if (strings % 6 == 0) begin
                pick = $urandom_range(9);
                if (pick == 0)
                    set_capacity(16'd1);
                else if (pick == 1)
                    set_capacity(16'd2);
                else if (pick == 2)
                    set_capacity(16'd65535);
                else if (pick == 3)
                    set_capacity(16'd256);
                else
                    set_capacity(16'($urandom_range(3, 24)));
            end
            send_random_string();
            strings++;
        end
    endtask

    // Hold the receiver off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        set_capacity(16'd65535);
        hold_request++;
        next_start = 1'b1;
        repeat (60) put_byte(8'($urandom_range(1, 127)));
        put_byte(8'h00);
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 16'h0000;
        cap_units     = MAX_UNITS_RESET;
        seq_pending   = PEND_NONE;
        seq_skipping  = 1'b0;
        seq_payload   = 16'h0000;
        units_written = 16'h0000;
        string_closed = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_request  = 0;
        next_start    = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_capacity();
        test_random_phase(220, 0, 0);
        test_random_phase(220, 74, 0);
        test_random_phase(220, 0, 74);
        test_random_phase(220, 38, 38);
        test_backpressure();

        settle();
        repeat (20) @(posedge aclk);
        $display("Sent %0d bytes over %0d capacity settings and four idling modes,",
                 bytes_sent, cap_writes);
        $display("checked %0d code units, %0d of them terminators, with one long hold-off.",
                 units_checked, terminators_seen);
        if (errors == 0 && awaited_units.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d units never arrived", errors, awaited_units.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_outq.sv
rtl/utf8_to_utf16_bmp_decoder_top.sv
verif/utf8_to_utf16_bmp_decoder_top_tb.sv
